// ===== src/pcp_pkg.sv =====
// ----------------------------------------------------------------------------
// pcp_pkg: shared types and constants of the pinhole camera projection
// Register indexes, reset values, internal widths and status codes.
// ----------------------------------------------------------------------------
package pcp_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int FIFO_DEPTH_DEF = 4;

    localparam int LOOK_W   = 32;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 4;
    localparam int OUT_W    = 48;
    localparam int STAT_W   = 2;

    // Rotated components fit in 69 signed bits; one spare bit is kept.
    localparam int ROT_W    = 70;
    localparam int MAG_W    = 69;
    // Quotient bits produced by the divider, and its saturation cap 2^62.
    localparam int QBITS    = 63;
    localparam logic [QBITS-1:0] QCAP = {1'b1, {(QBITS-1){1'b0}}};
    // Width of the signed sum center +/- offset before clamping.
    localparam int RES_W    = 66;
    localparam logic signed [RES_W-1:0] OUT_MAX = {{(RES_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [RES_W-1:0] OUT_MIN = {{(RES_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] REG_QUAT_W        = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_X        = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y        = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z        = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_SCALE    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_SCALE  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_CENTER   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_CENTER = 4'd7;

    localparam logic [CFG_W-1:0] RST_QUAT_W        = 32'd1073741824;
    localparam logic [CFG_W-1:0] RST_QUAT_X        = 32'd0;
    localparam logic [CFG_W-1:0] RST_QUAT_Y        = 32'd0;
    localparam logic [CFG_W-1:0] RST_QUAT_Z        = 32'd0;
    localparam logic [CFG_W-1:0] RST_LINE_SCALE    = 32'd65536;
    localparam logic [CFG_W-1:0] RST_SAMPLE_SCALE  = 32'd65536;
    localparam logic [CFG_W-1:0] RST_LINE_CENTER   = 32'd122683392;
    localparam logic [CFG_W-1:0] RST_SAMPLE_CENTER = 32'd184025088;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO = 2'd1;
    localparam logic [STAT_W-1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic signed [CFG_W-1:0] quat_w;
        logic signed [CFG_W-1:0] quat_x;
        logic signed [CFG_W-1:0] quat_y;
        logic signed [CFG_W-1:0] quat_z;
        logic [CFG_W-1:0]        line_scale;
        logic [CFG_W-1:0]        sample_scale;
        logic [CFG_W-1:0]        line_center;
        logic [CFG_W-1:0]        sample_center;
    } t_cfg;

    typedef struct packed {
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ROT_W-1:0] z;
    } t_rot;

endpackage

// ===== src/pcp_in_if.sv =====
// ----------------------------------------------------------------------------
// pcp_in_if: look vector channel
// Valid/ready channel carrying one look vector word.
// ----------------------------------------------------------------------------
interface pcp_in_if import pcp_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [LOOK_W-1:0] look_x;
    logic signed [LOOK_W-1:0] look_y;
    logic signed [LOOK_W-1:0] look_z;

    modport source (output valid, output look_x, output look_y, output look_z, input ready);
    modport sink   (input valid, input look_x, input look_y, input look_z, output ready);
endinterface

// ===== src/pcp_out_if.sv =====
// ----------------------------------------------------------------------------
// pcp_out_if: projected position channel
// Valid/ready channel carrying one line/sample/status word.
// ----------------------------------------------------------------------------
interface pcp_out_if import pcp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] line_pos;
    logic signed [OUT_W-1:0] sample_pos;
    logic [STAT_W-1:0]       status;

    modport source (output valid, output line_pos, output sample_pos, output status, input ready);
    modport sink   (input valid, input line_pos, input sample_pos, input status, output ready);
endinterface

// ===== src/pcp_front.sv =====
// ----------------------------------------------------------------------------
// pcp_front: quaternion rotation pipeline
// Five stages that turn a look vector into the camera frame vector X, Y, Z.
// ----------------------------------------------------------------------------
module pcp_front import pcp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    pcp_in_if.sink i_look,
    input  t_cfg   i_cfg,
    input  logic   i_full,
    output logic   o_push,
    output t_rot   o_rot
);

    localparam int PW = 64;   // 32x32 products
    localparam int KW = 66;   // sums of products
    localparam int LW = 66;   // low partial product
    localparam int HW = 65;   // high partial product
    localparam int TW = 99;   // one full wide product
    localparam int SW = 100;  // weighted sum of the three terms

    logic [4:0] r_vld;
    logic       en;

    logic signed [LOOK_W-1:0] w, a, b, c, p, r, s;

    logic signed [PW-1:0] r_ww, r_aa, r_bb, r_cc;
    logic signed [PW-1:0] r_ap, r_br, r_cs, r_bs, r_cr, r_cp, r_as, r_ar, r_bp;
    logic signed [LOOK_W-1:0] r_p1, r_r1, r_s1;

    logic signed [KW-1:0] r_k, r_d, r_cx, r_cy, r_cz;
    logic signed [LOOK_W-1:0] r_p2, r_r2, r_s2;

    logic signed [KW-1:0]     m  [3][3];
    logic signed [LOOK_W-1:0] sm [3][3];

    logic signed [LW-1:0] r_plo [3][3];
    logic signed [HW-1:0] r_phi [3][3];
    logic signed [TW-1:0] r_tp  [3][3];
    logic signed [SW-1:0] tsum  [3];

    t_rot r_rot;

    assign w = i_cfg.quat_w;
    assign a = i_cfg.quat_x;
    assign b = i_cfg.quat_y;
    assign c = i_cfg.quat_z;
    assign p = i_look.look_x;
    assign r = i_look.look_y;
    assign s = i_look.look_z;

    // The whole pipe holds when its last word cannot enter the queue.
    assign en           = !(r_vld[4] && i_full);
    assign i_look.ready = en;
    assign o_push       = r_vld[4] && !i_full;
    assign o_rot        = r_rot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[3:0], i_look.valid};
        end
    end

    // Stage 1: the 32x32 products of the quaternion and the vector that the later stages use.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ww <= w * w;
            r_aa <= a * a;
            r_bb <= b * b;
            r_cc <= c * c;
            r_ap <= a * p;
            r_br <= b * r;
            r_cs <= c * s;
            r_bs <= b * s;
            r_cr <= c * r;
            r_cp <= c * p;
            r_as <= a * s;
            r_ar <= a * r;
            r_bp <= b * p;
            r_p1 <= p;
            r_r1 <= r;
            r_s1 <= s;
        end
    end

    // Stage 2: w^2 - |u|^2, u.v and the cross product u x v.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_k  <= KW'(r_ww) - KW'(r_aa) - KW'(r_bb) - KW'(r_cc);
            r_d  <= KW'(r_ap) + KW'(r_br) + KW'(r_cs);
            r_cx <= KW'(r_bs) - KW'(r_cr);
            r_cy <= KW'(r_cp) - KW'(r_as);
            r_cz <= KW'(r_ar) - KW'(r_bp);
            r_p2 <= r_p1;
            r_r2 <= r_r1;
            r_s2 <= r_s1;
        end
    end

    // Operand pairs of the three terms of each rotated component.
    always_comb begin
        m[0][0] = r_k;  sm[0][0] = r_p2;
        m[0][1] = r_d;  sm[0][1] = a;
        m[0][2] = r_cx; sm[0][2] = w;
        m[1][0] = r_k;  sm[1][0] = r_r2;
        m[1][1] = r_d;  sm[1][1] = b;
        m[1][2] = r_cy; sm[1][2] = w;
        m[2][0] = r_k;  sm[2][0] = r_s2;
        m[2][1] = r_d;  sm[2][1] = c;
        m[2][2] = r_cz; sm[2][2] = w;
    end

    // Stage 3: each 66x32 product is split in a low and a high half.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                for (int t = 0; t < 3; t++) begin
                    r_plo[j][t] <= $signed({1'b0, m[j][t][32:0]}) * sm[j][t];
                    r_phi[j][t] <= $signed(m[j][t][KW-1:33]) * sm[j][t];
                end
            end
        end
    end

    // Stage 4: join the halves.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                for (int t = 0; t < 3; t++) begin
                    r_tp[j][t] <= (TW'(r_phi[j][t]) <<< 33) + TW'(r_plo[j][t]);
                end
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            tsum[j] = SW'(r_tp[j][0]) + (SW'(r_tp[j][1]) <<< 1) - (SW'(r_tp[j][2]) <<< 1);
        end
    end

    // Stage 5: sum the terms and drop the Q1.30 scaling with a floor shift.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rot.x <= ROT_W'(tsum[0] >>> 30);
            r_rot.y <= ROT_W'(tsum[1] >>> 30);
            r_rot.z <= ROT_W'(tsum[2] >>> 30);
        end
    end

endmodule

// ===== src/pcp_fifo.sv =====
// ----------------------------------------------------------------------------
// pcp_fifo: queue between rotation and projection
// Small register queue that lets the two halves stall independently.
// ----------------------------------------------------------------------------
module pcp_fifo import pcp_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rot i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_rot o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_rot             r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue read while empty");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue fill count lost a word");

endmodule

// ===== src/pcp_div.sv =====
// ----------------------------------------------------------------------------
// pcp_div: pipelined restoring divider with saturation
// One quotient bit per stage; the quotient is capped at 2^62.
// ----------------------------------------------------------------------------
module pcp_div import pcp_pkg::*; #(
    parameter int N_W  = 125,
    parameter int D_W  = 85,
    parameter int SB_W = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [N_W-1:0]   i_n,
    input  logic [D_W-1:0]   i_d,
    input  logic [SB_W-1:0]  i_sb,
    output logic [QBITS-1:0] o_q,
    output logic [SB_W-1:0]  o_sb
);

    localparam int CW = D_W + QBITS;

    logic [CW-1:0]    r_rem [QBITS];
    logic [D_W-1:0]   r_dd  [QBITS];
    logic [QBITS-1:0] r_q   [QBITS+1];
    logic             r_ovf [QBITS+1];
    logic             r_nz  [QBITS+1];
    logic [SB_W-1:0]  r_sb  [QBITS+1];
    logic [QBITS-1:0] r_qo;
    logic [SB_W-1:0]  r_sbo;

    // A quotient of 2^63 or more saturates anyway, so it is caught up front
    // and the remaining stages only need 63 bits. A zero divisor lands here too.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= CW'(i_n);
            r_dd[0]  <= i_d;
            r_q[0]   <= '0;
            r_ovf[0] <= CW'(i_n) >= (CW'(i_d) << QBITS);
            r_nz[0]  <= (i_n != '0);
            r_sb[0]  <= i_sb;
        end
    end

    for (genvar k = 1; k <= QBITS; k++) begin : g_step
        localparam int BI = QBITS - k;
        logic [CW-1:0] dsh;
        logic          ge;

        assign dsh = CW'(r_dd[k-1]) << BI;
        assign ge  = (r_rem[k-1] >= dsh);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k]   <= r_q[k-1] | (ge ? (QBITS'(1) << BI) : '0);
                r_ovf[k] <= r_ovf[k-1];
                r_nz[k]  <= r_nz[k-1];
                r_sb[k]  <= r_sb[k-1];
            end
        end

        if (k < QBITS) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? r_rem[k-1] - dsh : r_rem[k-1];
                    r_dd[k]  <= r_dd[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!r_nz[QBITS]) begin
                r_qo <= '0;
            end else if (r_ovf[QBITS] || (r_q[QBITS] > QCAP)) begin
                r_qo <= QCAP;
            end else begin
                r_qo <= r_q[QBITS];
            end
            r_sbo <= r_sb[QBITS];
        end
    end

    assign o_q  = r_qo;
    assign o_sb = r_sbo;

endmodule

// ===== src/pcp_back.sv =====
// ----------------------------------------------------------------------------
// pcp_back: perspective division and pixel mapping
// Scales X and Y, divides by Z, adds the principal point and clamps.
// ----------------------------------------------------------------------------
module pcp_back import pcp_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_empty,
    input  t_rot       i_rot,
    output logic       o_pop,
    pcp_out_if.source  o_proj
);

    localparam int N_W     = MAG_W + CFG_W + FRAC_BITS;
    localparam int D_W     = MAG_W + 16;
    localparam int DIV_LAT = QBITS + 2;
    localparam int NSTG    = 3 + DIV_LAT + 1;
    localparam int UP      = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int DN      = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int CTR_W   = CFG_W + 8;
    localparam int HI_W    = MAG_W - 64 + CFG_W;

    logic [NSTG-1:0] r_vld;
    logic            en;

    logic [MAG_W-1:0] r_mx, r_my, r_mz, r_mz1, r_mz2;
    logic             r_sl, r_ss, r_zz, r_sl1, r_ss1, r_zz1, r_sl2, r_ss2, r_zz2;
    logic [63:0]      r_px0, r_px1, r_py0, r_py1;
    logic [HI_W-1:0]  r_px2, r_py2;
    logic [N_W-1:0]   r_nx, r_ny;

    logic [QBITS-1:0] q_l, q_s;
    logic [1:0]       sb_l;
    logic             sb_s;

    logic [CTR_W-1:0]        c_l, c_s;
    logic signed [RES_W-1:0] off_l, off_s, res_l, res_s;
    logic                    sat_l, sat_s;

    logic signed [OUT_W-1:0] r_line_pos, r_sample_pos;
    logic [STAT_W-1:0]       r_status;

    // The pipe moves unless a finished word in the output register is not taken.
    assign en    = !(r_vld[NSTG-1] && !o_proj.ready);
    assign o_pop = en && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], !i_empty};
        end
    end

    // Magnitudes and signs of the rotated vector.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mx <= MAG_W'(i_rot.x[ROT_W-1] ? -i_rot.x : i_rot.x);
            r_my <= MAG_W'(i_rot.y[ROT_W-1] ? -i_rot.y : i_rot.y);
            r_mz <= MAG_W'(i_rot.z[ROT_W-1] ? -i_rot.z : i_rot.z);
            r_sl <= i_rot.x[ROT_W-1] ^ i_rot.z[ROT_W-1];
            r_ss <= i_rot.y[ROT_W-1] ^ i_rot.z[ROT_W-1];
            r_zz <= (i_rot.z == '0);
        end
    end

    // Scale products, cut into 32-bit slices of the magnitude.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px0 <= r_mx[31:0] * i_cfg.line_scale;
            r_px1 <= r_mx[63:32] * i_cfg.line_scale;
            r_px2 <= r_mx[MAG_W-1:64] * i_cfg.line_scale;
            r_py0 <= r_my[31:0] * i_cfg.sample_scale;
            r_py1 <= r_my[63:32] * i_cfg.sample_scale;
            r_py2 <= r_my[MAG_W-1:64] * i_cfg.sample_scale;
            r_mz1 <= r_mz;
            r_sl1 <= r_sl;
            r_ss1 <= r_ss;
            r_zz1 <= r_zz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nx <= (N_W'(r_px0) + (N_W'(r_px1) << 32) + (N_W'(r_px2) << 64)) << FRAC_BITS;
            r_ny <= (N_W'(r_py0) + (N_W'(r_py1) << 32) + (N_W'(r_py2) << 64)) << FRAC_BITS;
            r_mz2 <= r_mz1;
            r_sl2 <= r_sl1;
            r_ss2 <= r_ss1;
            r_zz2 <= r_zz1;
        end
    end

    pcp_div #(.N_W(N_W), .D_W(D_W), .SB_W(2)) u_div_line (
        .i_clk (i_clk),
        .i_en  (en),
        .i_n   (r_nx),
        .i_d   ({r_mz2, 16'b0}),
        .i_sb  ({r_sl2, r_zz2}),
        .o_q   (q_l),
        .o_sb  (sb_l)
    );

    pcp_div #(.N_W(N_W), .D_W(D_W), .SB_W(1)) u_div_sample (
        .i_clk (i_clk),
        .i_en  (en),
        .i_n   (r_ny),
        .i_d   ({r_mz2, 16'b0}),
        .i_sb  (r_ss2),
        .o_q   (q_s),
        .o_sb  (sb_s)
    );

    // Centers move from Q16.16 to the output fraction width.
    always_comb begin
        if (FRAC_BITS >= 16) begin
            c_l = CTR_W'(i_cfg.line_center) << UP;
            c_s = CTR_W'(i_cfg.sample_center) << UP;
        end else begin
            c_l = CTR_W'(i_cfg.line_center >> DN);
            c_s = CTR_W'(i_cfg.sample_center >> DN);
        end
        off_l = sb_l[1] ? -$signed(RES_W'(q_l)) : $signed(RES_W'(q_l));
        off_s = sb_s    ? -$signed(RES_W'(q_s)) : $signed(RES_W'(q_s));
        res_l = $signed(RES_W'(c_l)) - off_l;
        res_s = $signed(RES_W'(c_s)) + off_s;
        sat_l = (res_l > OUT_MAX) || (res_l < OUT_MIN);
        sat_s = (res_s > OUT_MAX) || (res_s < OUT_MIN);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (res_l > OUT_MAX) begin
                r_line_pos <= OUT_MAX[OUT_W-1:0];
            end else if (res_l < OUT_MIN) begin
                r_line_pos <= OUT_MIN[OUT_W-1:0];
            end else begin
                r_line_pos <= res_l[OUT_W-1:0];
            end
            if (res_s > OUT_MAX) begin
                r_sample_pos <= OUT_MAX[OUT_W-1:0];
            end else if (res_s < OUT_MIN) begin
                r_sample_pos <= OUT_MIN[OUT_W-1:0];
            end else begin
                r_sample_pos <= res_s[OUT_W-1:0];
            end
            if (sb_l[0]) begin
                r_status <= ST_ZERO;
            end else if (sat_l || sat_s) begin
                r_status <= ST_SAT;
            end else begin
                r_status <= ST_OK;
            end
        end
    end

    assign o_proj.valid      = r_vld[NSTG-1];
    assign o_proj.line_pos   = r_line_pos;
    assign o_proj.sample_pos = r_sample_pos;
    assign o_proj.status     = r_status;

endmodule

// ===== src/pinhole_camera_projection.sv =====
// ----------------------------------------------------------------------------
// pinhole_camera_projection: quaternion pinhole camera projection
// Maps look vectors to line/sample positions on the focal plane.
// ----------------------------------------------------------------------------
// Usage: look vector words enter on i_look and projected words leave on
// o_proj, both valid/ready channels. A word moves on a clock edge where valid
// and ready are both high. The attitude quaternion, scales and centers sit in
// eight registers written through i_cfg_we/i_cfg_idx/i_cfg_data; indexes past
// the last register are ignored. Write them only while no word is in flight.
// Throughput is one word per clock while the output receiver does not stall. A
// look vector passes five rotation stages, the queue and the projection stages,
// among them the two 63-stage restoring dividers, one quotient bit per stage.
// A rotation front end feeds a small queue, so input stays open while the
// output receiver stalls until the queue fills; the projection back end then
// holds its stages and its output register keeps the pending word stable.
// Reset clears all valid flags and loads the identity attitude, unit scales
// and the default principal point. Status reports a zero rotated z or a
// saturated coordinate.
// ----------------------------------------------------------------------------
module pinhole_camera_projection import pcp_pkg::*; #(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pcp_in_if.sink               i_look,
    pcp_out_if.source            o_proj,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg r_cfg;
    t_rot front_rot;
    t_rot fifo_rot;
    logic push;
    logic full;
    logic pop;
    logic empty;

    // Configuration registers; the quaternion stays in raw Q1.30 form.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.quat_w        <= RST_QUAT_W;
            r_cfg.quat_x        <= RST_QUAT_X;
            r_cfg.quat_y        <= RST_QUAT_Y;
            r_cfg.quat_z        <= RST_QUAT_Z;
            r_cfg.line_scale    <= RST_LINE_SCALE;
            r_cfg.sample_scale  <= RST_SAMPLE_SCALE;
            r_cfg.line_center   <= RST_LINE_CENTER;
            r_cfg.sample_center <= RST_SAMPLE_CENTER;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_QUAT_W:        r_cfg.quat_w        <= i_cfg_data;
                REG_QUAT_X:        r_cfg.quat_x        <= i_cfg_data;
                REG_QUAT_Y:        r_cfg.quat_y        <= i_cfg_data;
                REG_QUAT_Z:        r_cfg.quat_z        <= i_cfg_data;
                REG_LINE_SCALE:    r_cfg.line_scale    <= i_cfg_data;
                REG_SAMPLE_SCALE:  r_cfg.sample_scale  <= i_cfg_data;
                REG_LINE_CENTER:   r_cfg.line_center   <= i_cfg_data;
                REG_SAMPLE_CENTER: r_cfg.sample_center <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front end: rotates each vector into the camera frame.
    pcp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_look  (i_look),
        .i_cfg   (r_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_rot   (front_rot)
    );

    // The queue decouples the rotation stall from the output stall.
    pcp_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_rot),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (fifo_rot)
    );

    // Back end: divides by z and maps to pixel coordinates.
    pcp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (empty),
        .i_rot   (fifo_rot),
        .o_pop   (pop),
        .o_proj  (o_proj)
    );

endmodule

// ===== test/pcp_checker.sv =====
// ----------------------------------------------------------------------------
// pcp_checker: projection scoreboard
// Watches the look vector, the projected position and the register write
// port, predicts each projected word and compares it with what comes out.
// ----------------------------------------------------------------------------
module pcp_checker import pcp_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pcp_in_if                    i_look,
    pcp_out_if                   i_proj,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_errors,
    output int                   o_pending
);

    localparam int W = 200;
    typedef logic signed [W-1:0] t_big;

    typedef struct {
        logic signed [OUT_W-1:0] line_pos;
        logic signed [OUT_W-1:0] sample_pos;
        logic [STAT_W-1:0]       status;
    } t_position;

    t_cfg      cam;
    t_position positions_due[$];

    function automatic logic signed [OUT_W-1:0] image_coord(
        input t_big num, input t_big den, input logic [CFG_W-1:0] scale,
        input logic [CFG_W-1:0] center, input bit minus, output bit clamped);
        t_big nm, dm, n, c, q, off, r;
        t_big qcap;
        qcap = t_big'(1) <<< 62;
        nm = (num < 0) ? -num : num;
        dm = (den < 0) ? -den : den;
        n = (nm * t_big'({1'b0, scale})) <<< FRAC_BITS;
        c = t_big'({1'b0, center});
        c = (FRAC_BITS >= 16) ? (c <<< (FRAC_BITS - 16)) : (c >>> (16 - FRAC_BITS));
        if (dm == 0) begin
            q = (n == 0) ? t_big'(0) : qcap;
        end else begin
            q = n / (dm <<< 16);
            if (q > qcap) q = qcap;
        end
        off = ((num < 0) != (den < 0)) ? -q : q;
        r = minus ? c - off : c + off;
        clamped = 1'b0;
        if (r > t_big'(OUT_MAX)) begin
            r = t_big'(OUT_MAX);
            clamped = 1'b1;
        end
        if (r < t_big'(OUT_MIN)) begin
            r = t_big'(OUT_MIN);
            clamped = 1'b1;
        end
        return r[OUT_W-1:0];
    endfunction

    function automatic t_position project_look(input t_cfg cf, input logic signed [LOOK_W-1:0] lx,
                                               input logic signed [LOOK_W-1:0] ly,
                                               input logic signed [LOOK_W-1:0] lz);
        t_big w, a, b, c, p, r, s, k, d, cx, cy, cz, rx, ry, rz;
        bit sat_l, sat_s;
        t_position res;
        w = cf.quat_w; a = cf.quat_x; b = cf.quat_y; c = cf.quat_z;
        p = lx; r = ly; s = lz;
        // Exact sandwich: (w^2-|u|^2) v + 2 (u.v) u - 2 w (u x v), then Q1.30 floor.
        k = w * w - a * a - b * b - c * c;
        d = a * p + b * r + c * s;
        cx = b * s - c * r;
        cy = c * p - a * s;
        cz = a * r - b * p;
        rx = (k * p + 2 * d * a - 2 * w * cx) >>> 30;
        ry = (k * r + 2 * d * b - 2 * w * cy) >>> 30;
        rz = (k * s + 2 * d * c - 2 * w * cz) >>> 30;
        res.line_pos   = image_coord(rx, rz, cf.line_scale, cf.line_center, 1'b1, sat_l);
        res.sample_pos = image_coord(ry, rz, cf.sample_scale, cf.sample_center, 1'b0, sat_s);
        if (rz == 0) res.status = ST_ZERO;
        else if (sat_l || sat_s) res.status = ST_SAT;
        else res.status = ST_OK;
        return res;
    endfunction

    assign o_pending = positions_due.size();

    always @(posedge i_clk) begin
        t_position want;
        if (!i_rst_n) begin
            cam <= '{RST_QUAT_W, RST_QUAT_X, RST_QUAT_Y, RST_QUAT_Z, RST_LINE_SCALE,
                     RST_SAMPLE_SCALE, RST_LINE_CENTER, RST_SAMPLE_CENTER};
            positions_due.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_QUAT_W:        cam.quat_w        <= i_cfg_data;
                    REG_QUAT_X:        cam.quat_x        <= i_cfg_data;
                    REG_QUAT_Y:        cam.quat_y        <= i_cfg_data;
                    REG_QUAT_Z:        cam.quat_z        <= i_cfg_data;
                    REG_LINE_SCALE:    cam.line_scale    <= i_cfg_data;
                    REG_SAMPLE_SCALE:  cam.sample_scale  <= i_cfg_data;
                    REG_LINE_CENTER:   cam.line_center   <= i_cfg_data;
                    REG_SAMPLE_CENTER: cam.sample_center <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_look.valid && i_look.ready)
                positions_due.push_back(project_look(cam, i_look.look_x, i_look.look_y,
                                                     i_look.look_z));
            if (i_proj.valid && i_proj.ready) begin
                if (positions_due.size() == 0) begin
                    $error("projected word with nothing expected");
                    o_errors <= o_errors + 1;
                end else begin
                    want = positions_due.pop_front();
                    if (i_proj.line_pos !== want.line_pos ||
                        i_proj.sample_pos !== want.sample_pos ||
                        i_proj.status !== want.status) begin
                        o_errors <= o_errors + 1;
                        if (i_proj.line_pos !== want.line_pos)
                            $error("line_pos expected %0d got %0d", want.line_pos,
                                   i_proj.line_pos);
                        if (i_proj.sample_pos !== want.sample_pos)
                            $error("sample_pos expected %0d got %0d", want.sample_pos,
                                   i_proj.sample_pos);
                        if (i_proj.status !== want.status)
                            $error("status expected %0d got %0d", want.status,
                                   i_proj.status);
                    end
                end
            end
        end
    end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: pinhole camera projection
// Drives look vectors under a series of attitudes, scales and centers, with
// random gaps and output stalls; a checker predicts and compares each word.
// ----------------------------------------------------------------------------
module testbench;
    import pcp_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    int                   errors;
    int                   pending;
    int                   cycles = 0;
    bit                   stall_request = 1'b0;
    bit                   always_ready = 1'b0;

    pcp_in_if  look_ch ();
    pcp_out_if proj_ch ();

    initial begin
        look_ch.valid = 1'b0;
        look_ch.look_x = '0;
        look_ch.look_y = '0;
        look_ch.look_z = '0;
        proj_ch.ready = 1'b0;
    end

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    pinhole_camera_projection DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_look     (look_ch),
        .o_proj     (proj_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    pcp_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_look     (look_ch),
        .i_proj     (proj_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    // Watchdog: stops a hung run and reports it as failed.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == 600000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Most gaps are zero or a few cycles; now and then a long one.
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 95) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    // Output receiver. A long hold-off on request lets the rotation queue fill
    // so that the block has to stop taking look vectors.
    initial begin
        int hold;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (stall_request) begin
                proj_ch.ready <= 1'b0;
                for (hold = 0; hold < 300; hold++) @(posedge i_clk);
                stall_request = 1'b0;
            end else if (always_ready) begin
                proj_ch.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                hold = gap_len();
                if (hold > 0) begin
                    proj_ch.ready <= 1'b0;
                    repeat (hold) @(posedge i_clk);
                end
                proj_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    // Offers one word; valid stays high across back-to-back words and is only
    // dropped for a gap.
    task automatic send_look(input logic [31:0] lx, input logic [31:0] ly,
                             input logic [31:0] lz, input int gap);
        if (gap > 0) begin
            look_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        look_ch.valid  <= 1'b1;
        look_ch.look_x <= lx;
        look_ch.look_y <= ly;
        look_ch.look_z <= lz;
        do @(posedge i_clk); while (!look_ch.ready);
    endtask

    // Registers change only with nothing in flight; the task waits until the checker
    // has no word pending, and the extra cycles after that are spare margin.
    task automatic drain();
        look_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // The enable is dropped after each write, so it falls and rises again on
    // different edges.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // Full-range, small, or extreme component values.
    function automatic logic [31:0] look_value(input bit big);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        if (roll < 4 && !big) return 32'($urandom_range(0, 4000)) - 32'd2000;
        if (big) return ($urandom_range(0, 1) != 0) ? $urandom | 32'h4000_0000
                                                     : $urandom | 32'h8000_0000;
        return $urandom;
    endfunction

    logic [31:0] quat_set[4];
    logic [31:0] optics[4];

    initial begin
        int phase;
        int n;
        int i;
        logic [31:0] q;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words under the reset attitude: zero vector, zero z with
        // a nonzero numerator, on-axis, and the field extremes.
        send_look(32'd0, 32'd0, 32'd0, 0);
        send_look(32'd5, 32'hFFFF_FFFB, 32'd0, 0);
        send_look(32'd0, 32'd0, 32'd1000, 0);
        send_look(32'd100, 32'd200, 32'd1000, 1);
        send_look(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 0);
        send_look(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
        send_look(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 2);
        send_look(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        send_look(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 0);
        send_look(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 0);
        drain();

        // Register extremes; a write to an unused index must change nothing.
        write_reg(REG_QUAT_W, 32'h7FFF_FFFF);
        write_reg(REG_QUAT_X, 32'h8000_0000);
        write_reg(REG_QUAT_Y, 32'h7FFF_FFFF);
        write_reg(REG_QUAT_Z, 32'h8000_0000);
        write_reg(REG_LINE_SCALE, 32'hFFFF_FFFF);
        write_reg(REG_SAMPLE_SCALE, 32'd0);
        write_reg(REG_LINE_CENTER, 32'hFFFF_FFFF);
        write_reg(REG_SAMPLE_CENTER, 32'd0);
        write_reg(4'hF, 32'h1234_5678);
        write_reg(4'h8, 32'hFFFF_FFFF);
        send_look(32'd0, 32'd0, 32'd0, 0);
        send_look(32'd1000, 32'd2000, 32'd3000, 0);
        send_look(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_look(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        send_look(32'd1, 32'hFFFF_FFFF, 32'd1, 0);
        drain();

        for (phase = 0; phase < 8; phase++) begin
            // Attitude: reset-like, random components within +/-0.25 in Q1.30, or raw random bits.
            for (i = 0; i < 4; i++) begin
                case (phase % 3)
                    0: q = (i == 0) ? 32'h4000_0000 : 32'($urandom_range(0, 2000)) - 32'd1000;
                    1: q = 32'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000;
                    default: q = $urandom;
                endcase
                quat_set[i] = q;
            end
            optics[0] = (phase == 1) ? 32'd0 : $urandom_range(32'h0001_0000, 32'h0FA0_0000);
            optics[1] = (phase == 2) ? 32'hFFFF_FFFF : $urandom_range(32'h0001_0000,
                                                                        32'h0FA0_0000);
            optics[2] = (phase == 3) ? 32'd0 : $urandom;
            optics[3] = (phase == 4) ? 32'hFFFF_FFFF : $urandom;
            write_reg(REG_QUAT_W, quat_set[0]);
            write_reg(REG_QUAT_X, quat_set[1]);
            write_reg(REG_QUAT_Y, quat_set[2]);
            write_reg(REG_QUAT_Z, quat_set[3]);
            write_reg(REG_LINE_SCALE, optics[0]);
            write_reg(REG_SAMPLE_SCALE, optics[1]);
            write_reg(REG_LINE_CENTER, optics[2]);
            write_reg(REG_SAMPLE_CENTER, optics[3]);

            always_ready = (phase == 5);
            for (n = 0; n < 205; n++) begin
                if (phase == 2 && n == 50) stall_request = 1'b1;
                send_look(look_value(1'b0), look_value(1'b0),
                          look_value($urandom_range(0, 3) != 0),
                          (phase == 5 || phase == 6) ? 0 : gap_len());
            end
            drain();
        end

        always_ready = 1'b1;
        drain();
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/pcp_pkg.sv
src/pcp_in_if.sv
src/pcp_out_if.sv
src/pcp_front.sv
src/pcp_fifo.sv
src/pcp_div.sv
src/pcp_back.sv
src/pinhole_camera_projection.sv
test/pcp_checker.sv
test/testbench.sv
